FILE: rtl/km2d_pkg.sv
// Shared types and constants for the 2D k-means block.
`default_nettype none
package km2d_pkg;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLUSTER_COUNT   = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ITERATION_LIMIT = 1'd1;
  localparam logic [3:0] CLUSTER_COUNT_RESET   = 4'd4;
  localparam logic [7:0] ITERATION_LIMIT_RESET = 8'd100;

  typedef struct packed {
    logic load;      // store input beat
    logic clr_count; // empty the store
    logic init_cen;  // load centroid from point
    logic clr_acc;   // clear sums and counts
    logic rd_pt;     // read point into working register
    logic cmp;       // distance compare step
    logic accum;     // add point to chosen cluster
    logic div_start; // start mean division
    logic emit;      // load output register
  } km2d_cmd_t;

  typedef struct packed {
    logic div_done;
    logic changed;
  } km2d_sts_t;
endpackage
`default_nettype wire

FILE: rtl/km2d_if.sv
// Valid/ready channel interface.
`default_nettype none
interface km2d_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/km2d_datapath.sv
// Datapath: point store, centroids, accumulators, distance and divider.
`default_nettype none
module km2d_datapath
  import km2d_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_CLUSTERS = 8,
  parameter int COORD_BITS = 16,
  parameter int PB = $clog2(MAX_POINTS),
  parameter int CB = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire km2d_cmd_t        cmd,
  input  wire [COORD_BITS-1:0]  in_x,
  input  wire [COORD_BITS-1:0]  in_y,
  input  wire [PB-1:0]          wr_addr,
  input  wire [PB-1:0]          rd_addr,
  input  wire [CB-1:0]          cen_sel,
  output logic [CB-1:0]         assign_rd,
  output logic [COORD_BITS-1:0] pt_x,
  output logic [COORD_BITS-1:0] pt_y,
  output km2d_sts_t             sts
);
  localparam int SB = COORD_BITS + PB + 1;
  localparam int DB = 2 * COORD_BITS + 1;
  localparam int DCB = $clog2(SB + 1);

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [CB-1:0] amem [MAX_POINTS];
  logic [COORD_BITS-1:0] cx [MAX_CLUSTERS];
  logic [COORD_BITS-1:0] cy [MAX_CLUSTERS];
  logic [SB-1:0] sx [MAX_CLUSTERS];
  logic [SB-1:0] sy [MAX_CLUSTERS];
  logic [PB:0] cnt [MAX_CLUSTERS];
  logic [CB-1:0] best;
  logic [DB-1:0] best_d;
  logic [COORD_BITS-1:0] dx, dy;
  logic [DB-1:0] d;
  logic first;
  logic moved;
  // divider state
  logic [SB-1:0] qx, qy, rx, ry;
  logic [PB+1:0] dvsr;
  logic [DCB-1:0] dcnt;
  logic busy;
  logic busy_q;
  logic [SB:0] tx, ty;

  always_ff @(posedge clk) begin
    if (cmd.load) mem[wr_addr] <= {in_x, in_y};
    if (cmd.rd_pt) begin
      {pt_x, pt_y} <= mem[rd_addr];
      assign_rd <= amem[rd_addr];
    end
  end

  assign dx = (pt_x >= cx[cen_sel]) ? pt_x - cx[cen_sel] : cx[cen_sel] - pt_x;
  assign dy = (pt_y >= cy[cen_sel]) ? pt_y - cy[cen_sel] : cy[cen_sel] - pt_y;
  assign d = DB'(dx * dx) + DB'(dy * dy);

  always_ff @(posedge clk) begin
    if (cmd.rd_pt) first <= 1'b1;
    if (cmd.init_cen) begin
      cx[cen_sel] <= pt_x;
      cy[cen_sel] <= pt_y;
    end
    if (cmd.cmp) begin
      first <= 1'b0;
      if (first || d < best_d) begin
        best_d <= d;
        best <= cen_sel;
      end
    end
    if (cmd.clr_acc) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sx[i] <= '0;
        sy[i] <= '0;
        cnt[i] <= '0;
      end
    end
    if (cmd.accum) begin
      amem[rd_addr] <= best;
      sx[best] <= sx[best] + SB'(pt_x);
      sy[best] <= sy[best] + SB'(pt_y);
      cnt[best] <= cnt[best] + 1'b1;
    end
    if (cmd.div_start) moved <= 1'b0;
    // write back centroid once the division has finished
    if (busy_q && !busy) begin
      if (COORD_BITS'(qx) != cx[cen_sel] || COORD_BITS'(qy) != cy[cen_sel])
        moved <= 1'b1;
      cx[cen_sel] <= COORD_BITS'(qx);
      cy[cen_sel] <= COORD_BITS'(qy);
    end
  end

  // restoring division of both sums by the member count, one bit a cycle
  assign tx = {rx, qx[SB-1]} - (SB+1)'(dvsr);
  assign ty = {ry, qy[SB-1]} - (SB+1)'(dvsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy && !cmd.div_start;
      if (cmd.div_start) begin
        qx <= sx[cen_sel];
        qy <= sy[cen_sel];
        rx <= '0;
        ry <= '0;
        dvsr <= (PB+2)'(cnt[cen_sel]);
        dcnt <= DCB'(SB);
        busy <= (cnt[cen_sel] != '0);
      end else if (busy) begin
        if (!tx[SB]) begin
          rx <= tx[SB-1:0];
          qx <= {qx[SB-2:0], 1'b1};
        end else begin
          rx <= {rx[SB-2:0], qx[SB-1]};
          qx <= {qx[SB-2:0], 1'b0};
        end
        if (!ty[SB]) begin
          ry <= ty[SB-1:0];
          qy <= {qy[SB-2:0], 1'b1};
        end else begin
          ry <= {ry[SB-2:0], qy[SB-1]};
          qy <= {qy[SB-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
        if (dcnt == DCB'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sts = '{div_done: (!busy && !cmd.div_start && !busy_q), changed: moved};
endmodule
`default_nettype wire

FILE: rtl/km2d_ctrl.sv
// Controller: load, seed, assign, update and listing sequence.
`default_nettype none
module km2d_ctrl
  import km2d_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_CLUSTERS = 8,
  parameter int PB = $clog2(MAX_POINTS),
  parameter int CB = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_last,
  output logic                in_ready,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic                out_last,
  input  wire [3:0]           cluster_count,
  input  wire [7:0]           iteration_limit,
  input  wire                 tie_lo,
  input  wire km2d_sts_t      sts,
  input  wire [CB-1:0]        assign_rd,
  output km2d_cmd_t           cmd,
  output logic [PB-1:0]       wr_addr,
  output logic [PB-1:0]       rd_addr,
  output logic [CB-1:0]       cen_sel,
  output logic [CB-1:0]       out_cluster
);
  localparam logic [3:0] S_LOAD = 4'd0, S_SEED_RD = 4'd1, S_SEED_WR = 4'd2,
    S_ITER = 4'd3, S_A_RD = 4'd4, S_A_CMP = 4'd5, S_A_ACC = 4'd6,
    S_U_START = 4'd7, S_U_WAIT = 4'd8, S_L_RD = 4'd9, S_L_CHK = 4'd10,
    S_L_OUT = 4'd11, S_DONE = 4'd12;
  localparam int KB = CB + 1;

  logic [3:0] state;
  logic [KB-1:0] k;
  logic [7:0] limit, iters;
  logic changed;
  logic [PB:0] count;
  logic [PB:0] idx;
  logic [KB-1:0] c;
  logic [PB+KB:0] seed_acc;
  logic [PB:0] seed_idx;
  logic [PB:0] sent;

  always_comb begin
    if (cluster_count == 4'd0) k = KB'(1);
    else if (32'(cluster_count) > MAX_CLUSTERS) k = KB'(MAX_CLUSTERS);
    else k = KB'(cluster_count);
  end
  assign limit = (iteration_limit == 8'd0) ? 8'd1 : iteration_limit;

  assign in_ready = (state == S_LOAD) && !tie_lo;
  assign wr_addr = PB'(count);

  always_comb begin
    cmd = '0;
    rd_addr = PB'(idx);
    cen_sel = CB'(c);
    unique case (state)
      S_LOAD: cmd.load = in_valid && in_ready && (count < (PB+1)'(MAX_POINTS));
      S_SEED_RD: begin
        cmd.rd_pt = 1'b1;
        rd_addr = PB'(seed_idx);
      end
      S_SEED_WR: cmd.init_cen = 1'b1;
      S_ITER: cmd.clr_acc = 1'b1;
      S_A_RD: cmd.rd_pt = 1'b1;
      S_A_CMP: cmd.cmp = 1'b1;
      S_A_ACC: cmd.accum = 1'b1;
      S_U_START: cmd.div_start = 1'b1;
      S_L_RD: cmd.rd_pt = 1'b1;
      S_L_CHK: cmd.emit = (assign_rd == CB'(c)) && (!out_valid || out_ready);
      default: ;
    endcase
  end

  // seed index n*c/k by repeated subtraction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      // every point is listed once, so the n-th beat is the last
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_cluster <= CB'(c);
        out_last <= (sent == count - 1'b1);
        sent <= sent + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: if (in_valid && in_ready) begin
          if (cmd.load) count <= count + 1'b1;
          if (in_last) begin
            state <= S_SEED_RD;
            c <= '0;
            seed_acc <= '0;
            seed_idx <= '0;
          end
        end
        S_SEED_RD: begin
          // seed_acc holds n*c; reduce to index
          if (seed_acc >= (PB+KB+1)'(k)) begin
            seed_acc <= seed_acc - (PB+KB+1)'(k);
            seed_idx <= seed_idx + 1'b1;
          end else begin
            state <= S_SEED_WR;
          end
        end
        S_SEED_WR: begin
          if (c == k - 1'b1) begin
            state <= S_ITER;
            iters <= '0;
          end else begin
            c <= c + 1'b1;
            seed_acc <= (PB+KB+1)'((c + 1'b1)) * (PB+KB+1)'(count);
            seed_idx <= '0;
            state <= S_SEED_RD;
          end
        end
        S_ITER: begin
          idx <= '0;
          c <= '0;
          state <= S_A_RD;
        end
        S_A_RD: begin
          c <= '0;
          state <= S_A_CMP;
        end
        S_A_CMP: begin
          if (c == k - 1'b1) state <= S_A_ACC;
          else c <= c + 1'b1;
        end
        S_A_ACC: begin
          if (idx == count - 1'b1) begin
            c <= '0;
            changed <= 1'b0;
            state <= S_U_START;
          end else begin
            idx <= idx + 1'b1;
            state <= S_A_RD;
          end
        end
        S_U_START: state <= S_U_WAIT;
        S_U_WAIT: if (sts.div_done) begin
          if (sts.changed) changed <= 1'b1;
          if (c == k - 1'b1) begin
            iters <= iters + 1'b1;
            if ((iters + 1'b1) < limit && (changed || sts.changed)) state <= S_ITER;
            else begin
              c <= '0;
              idx <= '0;
              sent <= '0;
              state <= S_L_RD;
            end
          end else begin
            c <= c + 1'b1;
            state <= S_U_START;
          end
        end
        S_L_RD: state <= S_L_CHK;
        S_L_CHK: begin
          if (assign_rd != CB'(c) || !out_valid || out_ready) begin
            if (idx == count - 1'b1) begin
              idx <= '0;
              if (c == k - 1'b1) state <= S_L_OUT;
              else begin
                c <= c + 1'b1;
                state <= S_L_RD;
              end
            end else begin
              idx <= idx + 1'b1;
              state <= S_L_RD;
            end
          end
        end
        S_L_OUT: state <= S_DONE;
        default: begin
          count <= '0;
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/kmeans_2d_clustering_top.sv
// Top level of the 2D k-means clustering block.
//  channel  dir  payload
//  pts      in   point_x, point_y, last_point
//  res      out  cluster_index, point_index, out_x, out_y, last_result
//  cfg      in   we, index, data
// Points load at one beat per cycle; no beat is taken outside loading.
// Seeding reads one stored point per cluster. Each iteration assigns every point to
// its nearest centroid, then divides each cluster's sums by its member count to
// update its centroid (an empty cluster keeps its centroid).
// Listing scans every point once per cluster and holds while a beat waits.
// Synchronous reset empties the store and restores the register defaults.
`default_nettype none
module kmeans_2d_clustering_top
  import km2d_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_CLUSTERS = 8,
  parameter int COORD_BITS = 16
) (
  input wire clk,
  input wire rst,
  km2d_if.sink   pts,
  km2d_if.source res,
  input wire                     we,
  input wire [CFG_ADDR_BITS-1:0] index,
  input wire [CFG_DATA_BITS-1:0] data
);
  localparam int PB = $clog2(MAX_POINTS);
  localparam int CB = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  logic [3:0] cluster_count;
  logic [7:0] iteration_limit;
  km2d_cmd_t cmd;
  km2d_sts_t sts;
  logic [PB-1:0] wr_addr, rd_addr;
  logic [CB-1:0] cen_sel, assign_rd, out_cluster;
  logic [COORD_BITS-1:0] pt_x, pt_y;
  logic out_valid, out_last;
  logic [PB-1:0] opi;
  logic [COORD_BITS-1:0] ox, oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= CLUSTER_COUNT_RESET;
      iteration_limit <= ITERATION_LIMIT_RESET;
    end else if (we) begin
      unique case (index)
        REG_CLUSTER_COUNT: cluster_count <= data[3:0];
        REG_ITERATION_LIMIT: iteration_limit <= data;
        default: ;
      endcase
    end
  end

  km2d_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk, .rst, .in_valid(pts.valid), .in_last(pts.data[0]), .in_ready(pts.ready),
    .out_ready(res.ready), .out_valid, .out_last, .cluster_count, .iteration_limit,
    .tie_lo(1'b0), .sts, .assign_rd, .cmd, .wr_addr, .rd_addr, .cen_sel,
    .out_cluster
  );

  km2d_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS),
    .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .in_x(pts.data[2*COORD_BITS:COORD_BITS+1]),
    .in_y(pts.data[COORD_BITS:1]), .wr_addr, .rd_addr, .cen_sel,
    .assign_rd, .pt_x, .pt_y, .sts
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      opi <= rd_addr;
      ox <= pt_x;
      oy <= pt_y;
    end
  end

  assign res.valid = out_valid;
  assign res.data = {out_cluster, opi, ox, oy, out_last};
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for the 2D k-means clustering block: point sets in, listings checked.
module tb;
  import km2d_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } point_beat_t;

  typedef struct packed {
    logic [2:0]  cluster;
    logic [5:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } member_beat_t;

  localparam int NPTS = 64;
  localparam int NCL = 8;
  localparam longint CYCLE_LIMIT = 50000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] index = REG_CLUSTER_COUNT;
  logic [CFG_DATA_BITS-1:0] data = '0;

  km2d_if #(.W(33)) pts_ch ();
  km2d_if #(.W(42)) res_ch ();

  kmeans_2d_clustering_top DUT (
    .clk(clk), .rst(rst), .pts(pts_ch), .res(res_ch),
    .we(we), .index(index), .data(data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_beat_t  point_feed_q[$];
  member_beat_t listing_q[$];

  // shadow of the block
  logic [15:0] held_x[NPTS];
  logic [15:0] held_y[NPTS];
  int          held_n = 0;
  logic [3:0]  k_reg = CLUSTER_COUNT_RESET;
  logic [7:0]  lim_reg = ITERATION_LIMIT_RESET;

  int  mismatches = 0;
  int  sets_done = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  items_queued = 0;
  bit  idling = 1'b1;
  int  src_gap = 0;
  int  snk_gap = 0;
  longint cycles = 0;

  task automatic report(input string what);
    mismatches++;
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic predict_clustering();
    int k, lim, iter, c, i, best;
    logic [15:0] cx[NCL], cy[NCL];
    int owner[NPTS];
    longint unsigned sx[NCL], sy[NCL];
    int cnt[NCL];
    longint unsigned d, bd, dx, dy;
    bit moved;
    logic [15:0] mx, my;
    member_beat_t m;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > NCL) k = NCL;
    lim = lim_reg;
    if (lim == 0) lim = 1;
    for (c = 0; c < k; c++) begin
      cx[c] = held_x[(held_n * c) / k];
      cy[c] = held_y[(held_n * c) / k];
    end
    iter = 0;
    moved = 1'b1;
    while (iter < lim && moved) begin
      for (c = 0; c < NCL; c++) begin
        sx[c] = 0; sy[c] = 0; cnt[c] = 0;
      end
      for (i = 0; i < held_n; i++) begin
        best = 0;
        bd = 0;
        for (c = 0; c < k; c++) begin
          dx = (held_x[i] >= cx[c]) ? held_x[i] - cx[c] : cx[c] - held_x[i];
          dy = (held_y[i] >= cy[c]) ? held_y[i] - cy[c] : cy[c] - held_y[i];
          d = dx * dx + dy * dy;
          if (c == 0 || d < bd) begin
            bd = d;
            best = c;
          end
        end
        owner[i] = best;
        sx[best] += held_x[i];
        sy[best] += held_y[i];
        cnt[best]++;
      end
      moved = 1'b0;
      for (c = 0; c < k; c++) begin
        if (cnt[c] != 0) begin
          mx = 16'(sx[c] / cnt[c]);
          my = 16'(sy[c] / cnt[c]);
          if (mx != cx[c] || my != cy[c]) begin
            cx[c] = mx;
            cy[c] = my;
            moved = 1'b1;
          end
        end
      end
      iter++;
    end
    for (c = 0; c < k; c++)
      for (i = 0; i < held_n; i++)
        if (owner[i] == c) begin
          m.cluster = 3'(c);
          m.idx = 6'(i);
          m.x = held_x[i];
          m.y = held_y[i];
          m.last = 1'b0;
          listing_q.insert(listing_q.size(), m);
        end
    if (held_n > 0) listing_q[listing_q.size()-1].last = 1'b1;
    held_n = 0;
    sets_done++;
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      pts_ch.valid <= 1'b0;
      pts_ch.data <= '0;
      src_gap <= 0;
    end else if (!pts_ch.valid || pts_ch.ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        pts_ch.valid <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        src_gap <= $urandom_range(1, 12) - 1;
        pts_ch.valid <= 1'b0;
      end else if (point_feed_q.size() > 0) begin
        pts_ch.data <= point_feed_q.pop_front();
        pts_ch.valid <= 1'b1;
      end else begin
        pts_ch.valid <= 1'b0;
      end
    end
  end

  // listing receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      res_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      snk_gap <= $urandom_range(1, 12) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    point_beat_t  p;
    member_beat_t got, want;
    if (!rst) begin
      if (pts_ch.valid && pts_ch.ready) begin
        p = pts_ch.data;
        beats_in++;
        if (held_n < NPTS) begin
          held_x[held_n] = p.x;
          held_y[held_n] = p.y;
          held_n++;
        end
        if (p.last) predict_clustering();
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        beats_out++;
        if (listing_q.size() == 0) begin
          report($sformatf("unexpected beat %h", got));
        end else begin
          want = listing_q.pop_front();
          if (got.cluster != want.cluster)
            report($sformatf("cluster %0d, want %0d", got.cluster, want.cluster));
          if (got.idx != want.idx)
            report($sformatf("point index %0d, want %0d", got.idx, want.idx));
          if (got.x != want.x)
            report($sformatf("x %0d, want %0d", got.x, want.x));
          if (got.y != want.y)
            report($sformatf("y %0d, want %0d", got.y, want.y));
          if (got.last != want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout with %0d beats outstanding", listing_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] r, input logic [7:0] v);
    @(posedge clk);
    we <= 1'b1;
    index <= r;
    data <= v;
    @(posedge clk);
    we <= 1'b0;
    if (r == REG_CLUSTER_COUNT) k_reg = v[3:0];
    else lim_reg = v;
  endtask

  task automatic queue_point(input logic [15:0] x, input logic [15:0] y, input bit last);
    point_beat_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    point_feed_q.insert(point_feed_q.size(), p);
    items_queued++;
  endtask

  // block is idle once the listing is in and it takes points again
  task automatic drain();
    wait (point_feed_q.size() == 0);
    @(posedge clk);
    while (pts_ch.valid) @(posedge clk);
    while (listing_q.size() != 0) @(posedge clk);
    while (!pts_ch.ready) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int n, i, mode, ncent;
    logic [15:0] cxs[4], cys[4];
    logic [15:0] x, y;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corners at reset settings
    queue_point(16'h0000, 16'h0000, 0);
    queue_point(16'hFFFF, 16'hFFFF, 0);
    queue_point(16'h0000, 16'hFFFF, 0);
    queue_point(16'hFFFF, 16'h0000, 0);
    queue_point(16'h8000, 16'h0001, 1);
    drain();
    // lone point, more clusters than points
    write_reg(REG_CLUSTER_COUNT, 8'd8);
    queue_point(16'h5555, 16'hAAAA, 1);
    drain();
    // zero count and zero limit
    write_reg(REG_CLUSTER_COUNT, 8'd0);
    write_reg(REG_ITERATION_LIMIT, 8'd0);
    queue_point(16'd10, 16'd20, 0);
    queue_point(16'd30000, 16'd40000, 0);
    queue_point(16'hFFFF, 16'd7, 1);
    drain();
    // saturated count, top limit, duplicates and equidistant ties
    write_reg(REG_CLUSTER_COUNT, 8'd15);
    write_reg(REG_ITERATION_LIMIT, 8'd255);
    for (i = 0; i < 10; i++)
      queue_point((i % 3 == 0) ? 16'd100 : 16'd100 + 16'(2 * (i % 2)), 16'd50, i == 9);
    drain();

    while (items_queued < 260) begin
      if (items_queued > 210) idling = 1'b0;
      case ($urandom_range(0, 5))
        0: write_reg(REG_CLUSTER_COUNT, 8'($urandom_range(0, 15)));
        1: write_reg(REG_CLUSTER_COUNT, 8'd1);
        default: write_reg(REG_CLUSTER_COUNT, 8'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_ITERATION_LIMIT, 8'($urandom_range(0, 3)));
        1: write_reg(REG_ITERATION_LIMIT, 8'd255);
        default: write_reg(REG_ITERATION_LIMIT, 8'($urandom_range(4, 254)));
      endcase
      case ($urandom_range(0, 19))
        0: n = $urandom_range(65, 68);
        1, 2: n = $urandom_range(30, 64);
        default: n = $urandom_range(1, 12);
      endcase
      if (items_queued + n > 270) n = 270 - items_queued;
      mode = $urandom_range(0, 2);
      ncent = $urandom_range(1, 4);
      for (i = 0; i < 4; i++) begin
        cxs[i] = 16'($urandom);
        cys[i] = 16'($urandom);
      end
      for (i = 0; i < n; i++) begin
        if (mode == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else if (mode == 1) begin
          x = cxs[i % ncent] ^ 16'($urandom_range(0, 1023));
          y = cys[i % ncent] ^ 16'($urandom_range(0, 1023));
        end else begin
          x = 16'($urandom_range(0, 3));
          y = 16'($urandom_range(0, 3));
        end
        queue_point(x, y, i == n - 1);
      end
      drain();
    end

    $display("tb: %0d point sets, %0d point beats in, %0d listing beats out",
             sets_done, beats_in, beats_out);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/km2d_pkg.sv
rtl/km2d_if.sv
rtl/km2d_datapath.sv
rtl/km2d_ctrl.sv
rtl/kmeans_2d_clustering_top.sv
verif/tb.sv
